// ===== src/ccal_pkg.sv =====
package ccal_pkg;

   localparam int SEC_W      = 6;
   localparam int MIN_W      = 6;
   localparam int HOUR_W     = 5;
   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [SEC_W-1:0]   SEC_MAX     = 6'd59;
   localparam logic [MIN_W-1:0]   MIN_MAX     = 6'd59;
   localparam logic [HOUR_W-1:0]  HOUR_MAX    = 5'd23;
   localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
   localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_MAX   = 4'd12;
   localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
   localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd1000;

   // Divisibility by 25: multiply by the inverse of 25 modulo 2^14, then
   // the low product is at most floor((2^14 - 1) / 25) exactly for multiples.
   localparam logic [YEAR_W-1:0]  INV25       = 14'd7209;
   localparam logic [YEAR_W-1:0]  DIV25_LIMIT = 14'd655;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_HOUR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_MINUTE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_ARMED  = 2'd2;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
   } ccal_time_type;

   // Gregorian rule: leap = div4 and (not div100 or div400).
   // With div4 given, div100 is div25 and div400 is div16 and div25.
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [YEAR_W-1:0] prod;
      logic              div25;
      prod  = year * INV25;
      div25 = (prod <= DIV25_LIMIT);
      return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== src/ccal_next.sv =====
module ccal_next (
   input  ccal_pkg::ccal_time_type cur,
   input  logic                    operation,
   input  ccal_pkg::ccal_time_type load,
   output ccal_pkg::ccal_time_type nxt,
   output logic                    rejected
);
   import ccal_pkg::*;

   ccal_time_type    ticked;
   logic             sec_wrap;
   logic             min_wrap;
   logic             hour_wrap;
   logic             day_wrap;
   logic             month_wrap;
   logic [DAY_W-1:0] cur_len;
   logic [DAY_W-1:0] load_len;
   logic             load_ok;

   // carry chain for one-second advance
   always_comb begin
      cur_len    = month_length(cur.month, is_leap(cur.year));
      sec_wrap   = (cur.second >= SEC_MAX);
      min_wrap   = sec_wrap && (cur.minute >= MIN_MAX);
      hour_wrap  = min_wrap && (cur.hour >= HOUR_MAX);
      day_wrap   = hour_wrap && (cur.day >= cur_len);
      month_wrap = day_wrap && (cur.month >= MONTH_MAX);

      ticked        = cur;
      ticked.second = sec_wrap ? '0 : cur.second + 6'd1;
      if (sec_wrap) begin
         ticked.minute = min_wrap ? '0 : cur.minute + 6'd1;
      end
      if (min_wrap) begin
         ticked.hour = hour_wrap ? '0 : cur.hour + 5'd1;
      end
      if (hour_wrap) begin
         ticked.day = day_wrap ? DAY_FIRST : cur.day + 5'd1;
      end
      if (day_wrap) begin
         ticked.month = month_wrap ? MONTH_FIRST : cur.month + 4'd1;
      end
      if (month_wrap) begin
         ticked.year = (cur.year >= YEAR_MAX) ? '0 : cur.year + 14'd1;
      end
   end

   // range check of a load, day against the loaded month and year
   always_comb begin
      load_len = month_length(load.month, is_leap(load.year));
      load_ok  = (load.second <= SEC_MAX) && (load.minute <= MIN_MAX) &&
                 (load.hour <= HOUR_MAX) && (load.month >= MONTH_FIRST) &&
                 (load.month <= MONTH_MAX) && (load.year <= YEAR_MAX) &&
                 (load.day >= DAY_FIRST) && (load.day <= load_len);
   end

   always_comb begin
      if (operation == OP_TICK) begin
         nxt      = ticked;
         rejected = 1'b0;
      end else begin
         nxt      = load_ok ? load : cur;
         rejected = !load_ok;
      end
   end

endmodule

// ===== src/calendar_clock_with_alarm.sv =====
// Calendar clock with alarm compare. Each req word is either a one-second
// tick (req_operation = 0) or a load of a full date and time (req_operation
// = 1); every req word yields exactly one rsp word carrying the time and date
// after it, load_rejected for a load with any field out of range (day checked
// against the month length, Gregorian leap rule, year 0..9999) which leaves the
// clock untouched, and alarm_match when armed and hour and minute equal the
// alarm setting. After reset the clock reads 00:00:00, 1 January 1000, and
// the alarm registers are 0. Throughput is one word per cycle while rsp_ready
// does not hold the result register; a word passes the input register, then the
// carry chain and load check into the result register, where the clock state is
// also updated. The carry chain and leap test (one small constant multiply) sit
// in a single stage between the two registers. Alarm registers are written
// through the csr port (index 0 hour, 1 minute, 2 armed; other indexes are
// dropped) and should be written only while no word is in flight; csr_ready is always high.
module calendar_clock_with_alarm (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [ccal_pkg::SEC_W-1:0]        req_load_second,
   input  logic [ccal_pkg::MIN_W-1:0]        req_load_minute,
   input  logic [ccal_pkg::HOUR_W-1:0]       req_load_hour,
   input  logic [ccal_pkg::DAY_W-1:0]        req_load_day,
   input  logic [ccal_pkg::MONTH_W-1:0]      req_load_month,
   input  logic [ccal_pkg::YEAR_W-1:0]       req_load_year,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ccal_pkg::SEC_W-1:0]        rsp_second_now,
   output logic [ccal_pkg::MIN_W-1:0]        rsp_minute_now,
   output logic [ccal_pkg::HOUR_W-1:0]       rsp_hour_now,
   output logic [ccal_pkg::DAY_W-1:0]        rsp_day_now,
   output logic [ccal_pkg::MONTH_W-1:0]      rsp_month_now,
   output logic [ccal_pkg::YEAR_W-1:0]       rsp_year_now,
   output logic                              rsp_load_rejected,
   output logic                              rsp_alarm_match,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccal_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ccal_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ccal_pkg::*;

   // alarm registers
   logic [HOUR_W-1:0] alarm_hour_ff;
   logic [MIN_W-1:0]  alarm_minute_ff;
   logic              alarm_armed_ff;

   // input register
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_op_ff;
   ccal_time_type     s1_load_ff;

   // clock state
   ccal_time_type     time_ff;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   ccal_time_type     rsp_time_ff;
   logic              rsp_rejected_ff;
   logic              rsp_match_ff;

   logic              req_fire;
   logic              s1_fire;
   ccal_time_type     nxt_time;
   logic              nxt_rejected;
   logic              nxt_match;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_hour_ff   <= '0;
         alarm_minute_ff <= '0;
         alarm_armed_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ALARM_HOUR:   alarm_hour_ff   <= csr_data[HOUR_W-1:0];
            CSR_ALARM_MINUTE: alarm_minute_ff <= csr_data[MIN_W-1:0];
            CSR_ALARM_ARMED:  alarm_armed_ff  <= csr_data[0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // Advance the input register whenever the result register is empty or
   // being drained; accept a new word whenever the input register moves on.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_fire ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request payload until the next stage takes it
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff          <= req_operation;
         s1_load_ff.second <= req_load_second;
         s1_load_ff.minute <= req_load_minute;
         s1_load_ff.hour   <= req_load_hour;
         s1_load_ff.day    <= req_load_day;
         s1_load_ff.month  <= req_load_month;
         s1_load_ff.year   <= req_load_year;
      end
   end

   ccal_next u_next (
      .cur       (time_ff),
      .operation (s1_op_ff),
      .load      (s1_load_ff),
      .nxt       (nxt_time),
      .rejected  (nxt_rejected)
   );

   // alarm compare on the time after this word
   assign nxt_match = alarm_armed_ff && (nxt_time.hour == alarm_hour_ff) &&
                      (nxt_time.minute == alarm_minute_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff.second <= '0;
         time_ff.minute <= '0;
         time_ff.hour   <= '0;
         time_ff.day    <= DAY_FIRST;
         time_ff.month  <= MONTH_FIRST;
         time_ff.year   <= YEAR_RESET;
      end else if (s1_fire) begin
         time_ff <= nxt_time;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_time_ff     <= nxt_time;
         rsp_rejected_ff <= nxt_rejected;
         rsp_match_ff    <= nxt_match;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_second_now    = rsp_time_ff.second;
   assign rsp_minute_now    = rsp_time_ff.minute;
   assign rsp_hour_now      = rsp_time_ff.hour;
   assign rsp_day_now       = rsp_time_ff.day;
   assign rsp_month_now     = rsp_time_ff.month;
   assign rsp_year_now      = rsp_time_ff.year;
   assign rsp_load_rejected = rsp_rejected_ff;
   assign rsp_alarm_match   = rsp_match_ff;

   // clock state never leaves the valid calendar range
   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      (time_ff.second <= SEC_MAX) && (time_ff.minute <= MIN_MAX) &&
      (time_ff.hour <= HOUR_MAX) && (time_ff.day >= DAY_FIRST) &&
      (time_ff.day <= month_length(time_ff.month, is_leap(time_ff.year))) &&
      (time_ff.month >= MONTH_FIRST) && (time_ff.month <= MONTH_MAX) &&
      (time_ff.year <= YEAR_MAX))
      else $error("clock state out of range");

   // a rejected load leaves the clock untouched
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && nxt_rejected) |=> $stable(time_ff))
      else $error("rejected load changed the clock");

   // a tick is never flagged as rejected
   a_tick_not_rejected: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_op_ff == OP_TICK)) |=> !rsp_rejected_ff)
      else $error("tick flagged as rejected");

   // the response shows the clock state it produced
   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (rsp_time_ff == time_ff))
      else $error("response time differs from clock state");

endmodule
